[rtl/mtw_pkg.sv]
`timescale 1ns / 1ps
package mtw_pkg;

  localparam int unsigned TableWords  = 624;
  localparam int unsigned TwistOffset = 397;
  localparam int unsigned AddrW       = 10;

  localparam logic [AddrW-1:0] LastIdx     = AddrW'(TableWords - 1);
  localparam logic [AddrW-1:0] PosUsedUp   = AddrW'(TableWords);
  localparam logic [AddrW-1:0] PosUnseeded = AddrW'(TableWords + 1);
  localparam logic [AddrW-1:0] FarWrap     = AddrW'(TableWords - TwistOffset);
  localparam logic [AddrW-1:0] FarFwd      = AddrW'(TwistOffset);

  localparam logic [31:0] MatA        = 32'd2567483615;
  localparam logic [31:0] UpperBit    = 32'd2147483648;
  localparam logic [31:0] LowerBits   = 32'd2147483647;
  localparam logic [31:0] TemperB     = 32'd2636928640;
  localparam logic [31:0] TemperC     = 32'd4022730752;
  localparam logic [31:0] SeedMult    = 32'd69069;
  localparam logic [31:0] SeedDefault = 32'd4357;

  localparam logic CmdNext = 1'b0;
  localparam logic CmdSeed = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_TW_PRIME,
    ST_TW_LOAD,
    ST_TW_RD,
    ST_TW_WR,
    ST_WORD_RD,
    ST_WORD_OUT
  } mtw_state_e;

  typedef enum logic {
    WR_FILL,
    WR_TWIST
  } mtw_wr_sel_e;

  typedef enum logic {
    SEED_INPUT,
    SEED_DEFAULT
  } mtw_seed_sel_e;

  typedef struct packed {
    logic          mem_we;
    mtw_wr_sel_e   wr_sel;
    logic [AddrW-1:0] wr_addr;
    logic [AddrW-1:0] addr_a;
    logic [AddrW-1:0] addr_b;
    logic          load_seed;
    mtw_seed_sel_e seed_sel;
    logic          step_fill;
    logic          load_cur;
    logic          load_out;
  } mtw_cmd_t;

  typedef struct packed {
    logic out_free;
  } mtw_status_t;

  function automatic logic [31:0] twist_word(input logic [31:0] cur,
                                             input logic [31:0] nxt,
                                             input logic [31:0] far);
    logic [31:0] y;
    logic [31:0] v;
    y = (cur & UpperBit) | (nxt & LowerBits);
    v = far ^ (y >> 1);
    if (y[0]) begin
      v = v ^ MatA;
    end
    return v;
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

[rtl/mersenne_twister_word_generator.sv]
`timescale 1ns / 1ps
// channel  direction  handshake                payload
// in       input      in_valid_i / in_ready_o  command_i, seed_value_i
// out      output     out_valid_o / out_ready_i random_word_o
// cfg      input      psel/penable/pwrite      paddr, pwdata, prdata (default_seed at 0)
//
// a next word goes through accept, table read, output register load
// a seed command writes the table from the seed chain, one table write per cycle
// a used-up table is twisted first: prime and load steps, then one read step (next and
// far word) and one write step per word through the single write port of the table memory
// a request before any seed first fills the table from default_seed, then twists it
// reset clears control and loads default_seed with SeedDefault; the table holds garbage until seeded
// a full output register stalls the block in its last step until the word is taken
module mersenne_twister_word_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [31:0] seed_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] random_word_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mtw_pkg::*;

  mtw_cmd_t    cmd;
  mtw_status_t status;
  logic [31:0] default_seed_q;
  logic        seed_sel_hit;

  assign seed_sel_hit = (paddr[2] == 1'b0);
  assign pready       = 1'b1;
  assign prdata       = seed_sel_hit ? default_seed_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_seed_q <= SeedDefault;
    end else if (psel && penable && pwrite && seed_sel_hit) begin
      default_seed_q <= pwdata;
    end
  end

  mtw_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  mtw_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .seed_value_i   (seed_value_i),
    .default_seed_i (default_seed_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .random_word_o  (random_word_o)
  );

endmodule

[rtl/mtw_datapath.sv]
`timescale 1ns / 1ps
module mtw_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mtw_pkg::mtw_cmd_t    cmd_i,
  output mtw_pkg::mtw_status_t status_o,
  input  logic [31:0]         seed_value_i,
  input  logic [31:0]         default_seed_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         random_word_o
);
  import mtw_pkg::*;

  logic [31:0] mem [TableWords];
  logic [31:0] rda_q, rdb_q;
  logic [31:0] fill_q, fill_d;
  logic [31:0] cur_q;
  logic [31:0] out_q;
  logic        out_valid_q, out_valid_d;
  logic [31:0] wr_data;

  always_comb begin
    if (cmd_i.wr_sel == WR_TWIST) begin
      wr_data = twist_word(cur_q, rda_q, rdb_q);
    end else begin
      wr_data = fill_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem[cmd_i.wr_addr] <= wr_data;
    end
    rda_q <= mem[cmd_i.addr_a];
    rdb_q <= mem[cmd_i.addr_b];
  end

  // seed chain: each table word is the previous one times the multiplier
  always_comb begin
    fill_d = fill_q;
    if (cmd_i.load_seed) begin
      fill_d = (cmd_i.seed_sel == SEED_DEFAULT) ? default_seed_i : seed_value_i;
    end else if (cmd_i.step_fill) begin
      fill_d = fill_q * SeedMult;
    end
  end

  always_ff @(posedge clk_i) begin
    fill_q <= fill_d;
    if (cmd_i.load_cur) begin
      cur_q <= rda_q;
    end
    if (cmd_i.load_out) begin
      out_q <= temper(rda_q);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign random_word_o     = out_q;

endmodule

[rtl/mtw_controller.sv]
`timescale 1ns / 1ps
module mtw_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                command_i,
  output mtw_pkg::mtw_cmd_t    cmd_o,
  input  mtw_pkg::mtw_status_t status_i
);
  import mtw_pkg::*;

  mtw_state_e       state_q, state_d;
  logic [AddrW-1:0] pos_q, pos_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic             pend_q, pend_d;
  logic             accept;
  logic [AddrW-1:0] nxt_idx, far_idx;

  assign accept = (state_q == ST_IDLE) && in_valid_i;

  // neighbor and far index of the twist, both mod table size
  assign nxt_idx = (idx_q == LastIdx) ? '0 : idx_q + 1'b1;
  assign far_idx = (idx_q < FarWrap) ? idx_q + FarFwd : idx_q - FarWrap;

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    idx_d   = idx_q;
    pend_d  = pend_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          idx_d = '0;
          if (command_i == CmdSeed) begin
            pend_d  = 1'b0;
            state_d = ST_FILL;
          end else if (pos_q == PosUnseeded) begin
            pend_d  = 1'b1;
            state_d = ST_FILL;
          end else if (pos_q == PosUsedUp) begin
            state_d = ST_TW_PRIME;
          end else begin
            state_d = ST_WORD_RD;
          end
        end
      end
      ST_FILL: begin
        if (idx_q == LastIdx) begin
          idx_d   = '0;
          pos_d   = PosUsedUp;
          state_d = pend_q ? ST_TW_PRIME : ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_TW_PRIME: state_d = ST_TW_LOAD;
      ST_TW_LOAD:  state_d = ST_TW_RD;
      ST_TW_RD:    state_d = ST_TW_WR;
      ST_TW_WR: begin
        if (idx_q == LastIdx) begin
          idx_d   = '0;
          pos_d   = '0;
          state_d = ST_WORD_RD;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_TW_RD;
        end
      end
      ST_WORD_RD: state_d = ST_WORD_OUT;
      ST_WORD_OUT: begin
        if (status_i.out_free) begin
          pos_d   = pos_q + 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.wr_sel    = WR_FILL;
    cmd_o.seed_sel  = SEED_INPUT;
    cmd_o.wr_addr   = idx_q;
    in_ready_o      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_seed = accept;
        cmd_o.seed_sel  = (command_i == CmdSeed) ? SEED_INPUT : SEED_DEFAULT;
      end
      ST_FILL: begin
        cmd_o.mem_we    = 1'b1;
        cmd_o.step_fill = 1'b1;
      end
      ST_TW_PRIME: cmd_o.addr_a = '0;
      ST_TW_LOAD:  cmd_o.load_cur = 1'b1;
      ST_TW_RD: begin
        cmd_o.addr_a = nxt_idx;
        cmd_o.addr_b = far_idx;
      end
      ST_TW_WR: begin
        cmd_o.mem_we   = 1'b1;
        cmd_o.wr_sel   = WR_TWIST;
        cmd_o.load_cur = 1'b1;
      end
      ST_WORD_RD:  cmd_o.addr_a = pos_q;
      // keep reading the same word while the output register is full
      ST_WORD_OUT: begin
        cmd_o.addr_a   = pos_q;
        cmd_o.load_out = status_i.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= PosUnseeded;
      idx_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
    end
  end

endmodule

[test/mtw_word_checker.sv]
`timescale 1ns / 1ps
module mtw_word_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        command_i,
  input  logic [31:0] seed_value_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] random_word_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned words_o,
  output int unsigned seeds_o
);
  import mtw_pkg::*;

  localparam int unsigned Words      = 624;
  localparam int unsigned FarStep    = 397;
  localparam int unsigned RegDefSeed = 0;
  localparam int unsigned MaxReports = 10;

  localparam logic [31:0] TwistXor  = 32'h9908_B0DF;
  localparam logic [31:0] HighMask  = 32'h8000_0000;
  localparam logic [31:0] LowMask   = 32'h7FFF_FFFF;
  localparam logic [31:0] MaskB     = 32'h9D2C_5680;
  localparam logic [31:0] MaskC     = 32'hEFC6_0000;
  localparam logic [31:0] ChainMult = 32'd69069;
  localparam logic [31:0] SeedReset = 32'd4357;

  logic [31:0] mt_table [Words];
  logic [9:0]  read_pos;
  logic [31:0] seed_reg;
  logic [31:0] expected_words [$];
  logic [31:0] want;

  function automatic logic [31:0] temper_word(input logic [31:0] w);
    logic [31:0] t;
    t = w ^ (w >> 11);
    t = t ^ ((t << 7) & MaskB);
    t = t ^ ((t << 15) & MaskC);
    t = t ^ (t >> 18);
    return t;
  endfunction

  task automatic load_seed_chain(input logic [31:0] s);
    mt_table[0] = s;
    for (int i = 1; i < Words; i++) begin
      mt_table[i] = mt_table[i-1] * ChainMult;
    end
    read_pos = 10'(Words);
  endtask

  // in place, so the wrapped neighbors already hold their new values
  task automatic twist_all_words();
    logic [31:0] y;
    logic [31:0] v;
    int unsigned nxt;
    int unsigned far;
    for (int unsigned k = 0; k < Words; k++) begin
      nxt = (k + 1) % Words;
      far = (k + FarStep) % Words;
      y = (mt_table[k] & HighMask) | (mt_table[nxt] & LowMask);
      v = mt_table[far] ^ (y >> 1);
      if (y[0]) begin
        v = v ^ TwistXor;
      end
      mt_table[k] = v;
    end
    read_pos = '0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_pos = 10'(Words + 1);
      seed_reg = SeedReset;
      expected_words.delete();
      fail_count_o = 0;
      words_o = 0;
      seeds_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && (paddr_i >> 2) == RegDefSeed) begin
        seed_reg = pwdata_i;
      end
      if (in_valid_i && in_ready_i) begin
        if (command_i == CmdSeed) begin
          load_seed_chain(seed_value_i);
          seeds_o++;
        end else begin
          if (read_pos >= 10'(Words)) begin
            // never seeded: fall back to the default seed
            if (read_pos != 10'(Words)) begin
              load_seed_chain(seed_reg);
            end
            twist_all_words();
          end
          expected_words.push_back(temper_word(mt_table[read_pos]));
          read_pos++;
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= MaxReports) begin
            $display("%0t: word %h arrived with none expected", $time, random_word_i);
          end
        end else begin
          want = expected_words.pop_front();
          words_o++;
          if (want !== random_word_i) begin
            fail_count_o++;
            if (fail_count_o <= MaxReports) begin
              $display("%0t: random_word mismatch, expected %h got %h",
                       $time, want, random_word_i);
            end
          end
        end
      end
    end
    pending_o = expected_words.size();
  end

endmodule

[test/mersenne_twister_word_generator_tb.sv]
`timescale 1ns / 1ps
module mersenne_twister_word_generator_tb;
  import mtw_pkg::*;

  localparam int unsigned CycleLimit   = 4_000_000;
  localparam int unsigned SettleCycles = 1300;
  localparam logic [2:0]  AddrDefSeed  = 3'd0;
  localparam logic [2:0]  AddrNoReg    = 3'd4;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        command_i;
  logic [31:0] seed_value_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] random_word_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned words_checked;
  int unsigned seeds_seen;
  int unsigned cycle_count;
  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;

  mersenne_twister_word_generator i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .seed_value_i (seed_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .random_word_o(random_word_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  mtw_word_checker i_word_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .command_i    (command_i),
    .seed_value_i (seed_value_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .random_word_i(random_word_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .words_o      (words_checked),
    .seeds_o      (seeds_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("mersenne_twister_word_generator test failed");
    $finish;
  end

  // output side back-pressure
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // called and returns at a falling edge
  task automatic issue_request(input logic cmd, input logic [31:0] seed);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    seed_value_i <= seed;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
  endtask

  task automatic random_requests(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      issue_request(($urandom_range(11) == 0) ? CmdSeed : CmdNext, $urandom());
    end
  endtask

  // sender holds off until every word is back and a reseed has surely finished
  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (pending != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    command_i    = CmdNext;
    seed_value_i = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    snd_idle_pct = 27;
    rcv_idle_pct = 72;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    cfg_write(AddrDefSeed, 32'h0000_0000);
    cfg_write(AddrNoReg, $urandom());
    cfg_write(AddrDefSeed, 32'hFFFF_FFFF);
    @(negedge clk_i);

    // first words come from the default seed
    issue_request(CmdNext, 32'h0000_0000);
    issue_request(CmdNext, 32'hFFFF_FFFF);
    issue_request(CmdSeed, 32'h0000_0000);
    issue_request(CmdNext, 32'h1234_5678);
    issue_request(CmdNext, 32'h0000_0000);
    issue_request(CmdSeed, 32'hFFFF_FFFF);
    issue_request(CmdNext, 32'h0000_0000);
    issue_request(CmdNext, 32'hFFFF_FFFF);
    // back to back reseeds, only the last one counts
    issue_request(CmdSeed, 32'h0000_0001);
    issue_request(CmdSeed, 32'h8000_0000);
    issue_request(CmdNext, 32'h0000_0000);
    issue_request(CmdNext, 32'h0000_0000);
    issue_request(CmdSeed, 32'd5489);
    issue_request(CmdNext, 32'h5555_5555);
    issue_request(CmdNext, 32'hAAAA_AAAA);
    issue_request(CmdNext, 32'h0000_0000);
    issue_request(CmdSeed, 32'h7FFF_FFFF);
    issue_request(CmdNext, 32'h0000_0000);
    issue_request(CmdSeed, 32'd4357);
    issue_request(CmdNext, 32'h0000_0000);

    random_requests(80);
    drain_and_settle();

    cfg_write(AddrDefSeed, 32'h0000_0000);
    snd_idle_pct = 72;
    rcv_idle_pct = 27;
    @(negedge clk_i);
    random_requests(80);
    drain_and_settle();

    cfg_write(AddrDefSeed, $urandom());
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    @(negedge clk_i);
    // long unbroken run so the table is used up and twisted again
    issue_request(CmdSeed, $urandom());
    repeat (630) issue_request(CmdNext, $urandom());
    random_requests(40);
    drain_and_settle();

    $display("checked %0d words across %0d reseeds in %0d cycles, with idle mixes 27/72, 72/27",
             words_checked, seeds_seen, cycle_count);
    $display("and a gap-free run through a full table twist");
    if (fail_count == 0 && pending == 0) begin
      $display("mersenne_twister_word_generator test passed");
    end else begin
      $display("mersenne_twister_word_generator test failed");
    end
    $finish;
  end

endmodule
